[hw/rtl/ctsp_pkg.sv]
// ============================================================================
// ctsp_pkg: shared types, constants and binary32 arithmetic functions
// Holds the round-to-nearest-even add and multiply used by every pipeline
// stage of the compensated two-sum / two-product block.
// ============================================================================
package ctsp_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int NUM_STAGES = 9;

    localparam logic [31:0] CANON_NAN       = 32'h7FC0_0000;
    localparam logic [4:0]  SPLIT_SHIFT_RST = 5'd12;
    localparam logic [4:0]  SPLIT_SHIFT_MIN = 5'd1;
    localparam logic [4:0]  SPLIT_SHIFT_MAX = 5'd23;

    localparam logic OP_TWO_SUM  = 1'b0;
    localparam logic OP_TWO_PROD = 1'b1;

    // Per-stage load enables and valid flags from the flow control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_flow;

    // Normalizes and rounds sgn * m * 2^e to binary32, ties to even,
    // with gradual underflow and overflow to infinity. m must be nonzero.
    function automatic logic [31:0] fp_round(input logic sgn, input int e,
                                             input logic [50:0] m);
        logic [50:0] mn;
        logic [50:0] t;
        logic [50:0] mask;
        logic [23:0] mant;
        logic [40:0] tot;
        logic        g;
        logic        st;
        logic        lost;
        logic        up;
        int          lz;
        int          be;
        int          sh;
        lz = 0;
        for (int i = 0; i < 51; i++) begin
            if (m[i]) lz = 50 - i;
        end
        mn = m << lz;
        be = e + 50 - lz + 127;
        if (be >= 1) begin
            mant = mn[50:27];
            g    = mn[26];
            st   = |mn[25:0];
            tot  = 41'(be - 1) << 23;
        end else begin
            sh = 1 - be;
            if (sh >= 51) begin
                t    = '0;
                lost = |mn;
            end else begin
                mask = ~({51{1'b1}} << sh);
                t    = mn >> sh;
                lost = |(mn & mask);
            end
            mant = t[50:27];
            g    = t[26];
            st   = (|t[25:0]) | lost;
            tot  = '0;
        end
        up  = g & (st | mant[0]);
        tot = tot + 41'(mant) + 41'(up);
        if (tot >= (41'd255 << 23)) begin
            return {sgn, 8'hFF, 23'h0};
        end
        return {sgn, tot[30:0]};
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic        swap;
        logic [31:0] bg, sm;
        logic [23:0] mbg, msm;
        logic [50:0] wbg, wsm, full, mask, res;
        int          xbg, xsm, d;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        zero_a = (a[30:0] == '0);
        zero_b = (b[30:0] == '0);
        if (nan_a || nan_b) return CANON_NAN;
        if (inf_a && inf_b) return (a[31] != b[31]) ? CANON_NAN : a;
        if (inf_a) return a;
        if (inf_b) return b;
        if (zero_a && zero_b) return {a[31] & b[31], 31'h0};
        if (zero_a) return b;
        if (zero_b) return a;
        swap = (a[30:0] < b[30:0]);
        bg   = swap ? b : a;
        sm   = swap ? a : b;
        mbg  = {bg[30:23] != 8'h0, bg[22:0]};
        msm  = {sm[30:23] != 8'h0, sm[22:0]};
        xbg  = (bg[30:23] == 8'h0) ? 1 : int'(bg[30:23]);
        xsm  = (sm[30:23] == 8'h0) ? 1 : int'(sm[30:23]);
        d    = xbg - xsm;
        wbg  = {1'b0, mbg, 26'h0};
        full = {1'b0, msm, 26'h0};
        if (d >= 51) begin
            wsm = 51'd1;
        end else begin
            mask   = ~({51{1'b1}} << d);
            wsm    = full >> d;
            wsm[0] = wsm[0] | (|(full & mask));
        end
        if (bg[31] == sm[31]) begin
            res = wbg + wsm;
        end else begin
            res = wbg - wsm;
        end
        if (res == '0) return 32'h0;
        return fp_round(bg[31], xbg - 176, res);
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
        logic [23:0] ma, mb;
        logic [47:0] p;
        int          xa, xb;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        zero_a = (a[30:0] == '0);
        zero_b = (b[30:0] == '0);
        sgn    = a[31] ^ b[31];
        if (nan_a || nan_b) return CANON_NAN;
        if ((inf_a && zero_b) || (inf_b && zero_a)) return CANON_NAN;
        if (inf_a || inf_b) return {sgn, 8'hFF, 23'h0};
        if (zero_a || zero_b) return {sgn, 31'h0};
        ma = {a[30:23] != 8'h0, a[22:0]};
        mb = {b[30:23] != 8'h0, b[22:0]};
        xa = (a[30:23] == 8'h0) ? 1 : int'(a[30:23]);
        xb = (b[30:23] == 8'h0) ? 1 : int'(b[30:23]);
        p  = ma * mb;
        return fp_round(sgn, xa + xb - 300, 51'(p));
    endfunction

    // Splitter constant 2^s + 1 with s saturated to its legal range.
    function automatic logic [31:0] split_factor(input logic [4:0] shift);
        logic [4:0] s;
        s = shift;
        if (s < SPLIT_SHIFT_MIN) s = SPLIT_SHIFT_MIN;
        if (s > SPLIT_SHIFT_MAX) s = SPLIT_SHIFT_MAX;
        return {1'b0, 8'(8'd127 + 8'(s)), 23'(23'd1 << (5'd23 - s))};
    endfunction

endpackage

[hw/rtl/ctsp_flow.sv]
// ============================================================================
// ctsp_flow: valid/ready flow control for the datapath stages
// Each stage loads when it is empty or when the stage after it moves on.
// ============================================================================
module ctsp_flow (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output ctsp_pkg::t_flow o_flow
);

    logic [ctsp_pkg::NUM_STAGES-1:0] r_vld;
    logic [ctsp_pkg::NUM_STAGES-1:0] n_vld;
    logic [ctsp_pkg::NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[ctsp_pkg::NUM_STAGES-1] = !r_vld[ctsp_pkg::NUM_STAGES-1] || i_out_ready;
        for (int k = ctsp_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < ctsp_pkg::NUM_STAGES; k++) begin
            n_vld[k] = rdy[k] ? (r_vld[k-1] && rdy[k-1] ? 1'b1 : 1'b0) : r_vld[k];
        end
    end

    // A stage upstream that is valid but cannot advance keeps its beat; that
    // happens only while the stage below it also holds, so no bubble forms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = rdy[0];
    assign o_flow.en  = rdy;
    assign o_flow.vld = r_vld;

endmodule

[hw/rtl/compensated_two_sum_two_product.sv]
// ============================================================================
// compensated_two_sum_two_product: error-free binary32 sum and product
// Nine-stage pipeline giving the rounded result and the updated error word.
// ============================================================================
// Usage: one input beat carries an op, two binary32 operands, an incoming
// error word and an overwrite flag. The op two_sum returns a+b and folds the
// exact round-off into the error word (or replaces it when the overwrite flag
// is set). The op two_product returns a*b and adds the Dekker round-off,
// computed with a Veltkamp split whose constant is 2^s + 1, to the error word.
// Every floating-point step rounds to nearest, ties to even.
// Both channels use valid/ready; a beat moves when both are high.
// One beat may be accepted every cycle unless an output stall has filled
// every stage; the longest dependent chain of the two-product transform
// (nine rounded operations, one per stage, with one add or multiply per
// stage path) sets the depth. Reset clears every stage valid flag and loads
// the split shift with 12. When the receiver stalls, the output register
// holds its beat and each stage above fills any bubble below it before the
// input ready drops, so nothing is lost or repeated. The user must write the
// split shift only while idle; the block itself does not enforce this.
// ============================================================================
module compensated_two_sum_two_product (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_error_in,
    input  logic        i_error_overwrite,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_value,
    output logic [31:0] o_error_out
);

    ctsp_pkg::t_flow flow;
    logic [4:0]      r_split_shift;
    logic [31:0]     factor;

    // Stage 1: product or sum, plus both splitter multiplies.
    logic        r1_op, r1_ovw;
    logic [31:0] r1_a, r1_b, r1_err, r1_x, r1_ca, r1_cb;
    logic [31:0] n1_x, n1_ca, n1_cb;
    // Stage 2: splitter differences c-a and c-b, or b-virtual for the sum.
    logic        r2_op, r2_ovw;
    logic [31:0] r2_a, r2_b, r2_err, r2_x, r2_ca, r2_cb, r2_d1, r2_d2;
    logic [31:0] n2_d1, n2_d2;
    // Stage 3: high halves, or a-virtual and b-round-off.
    logic        r3_op, r3_ovw;
    logic [31:0] r3_a, r3_b, r3_err, r3_x, r3_h1, r3_h2;
    logic [31:0] n3_h1, n3_h2;
    // Stage 4: low halves and high-by-high product, or the sum's a-round-off.
    logic        r4_op, r4_ovw;
    logic [31:0] r4_err, r4_x, r4_h1, r4_h2, r4_l1, r4_l2, r4_p1;
    logic [31:0] n4_l1, n4_l2, n4_p1;
    // Stage 5: first error term or the sum round-off, and cross products.
    logic        r5_op, r5_ovw;
    logic [31:0] r5_err, r5_x, r5_e, r5_p2, r5_p3, r5_p4;
    logic [31:0] n5_e, n5_p2, n5_p3, n5_p4;
    // Stages 6 to 8: remaining subtraction chain of the product round-off.
    logic        r6_op, r7_op, r8_op;
    logic [31:0] r6_err, r6_x, r6_e, r6_p3, r6_p4;
    logic [31:0] r7_err, r7_x, r7_e, r7_p4;
    logic [31:0] r8_err, r8_x, r8_e;
    logic [31:0] n6_e, n7_e, n8_e;
    // Stage 9: output register.
    logic [31:0] r9_x, r9_err;
    logic [31:0] n9_err;

    ctsp_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_flow      (flow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_shift <= ctsp_pkg::SPLIT_SHIFT_RST;
        end else if (i_cfg_we) begin
            r_split_shift <= i_cfg_wdata;
        end
    end

    assign factor = ctsp_pkg::split_factor(r_split_shift);

    // Datapath, one rounded operation deep per stage along each path.
    always_comb begin
        n1_x  = (i_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_mul(i_operand_a, i_operand_b)
                                                : ctsp_pkg::fp_add(i_operand_a, i_operand_b);
        n1_ca = ctsp_pkg::fp_mul(factor, i_operand_a);
        n1_cb = ctsp_pkg::fp_mul(factor, i_operand_b);

        n2_d1 = (r1_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_sub(r1_ca, r1_a)
                                                 : ctsp_pkg::fp_sub(r1_x, r1_a);
        n2_d2 = ctsp_pkg::fp_sub(r1_cb, r1_b);

        n3_h1 = ctsp_pkg::fp_sub((r2_op == ctsp_pkg::OP_TWO_PROD) ? r2_ca : r2_x, r2_d1);
        n3_h2 = ctsp_pkg::fp_sub((r2_op == ctsp_pkg::OP_TWO_PROD) ? r2_cb : r2_b,
                                 (r2_op == ctsp_pkg::OP_TWO_PROD) ? r2_d2 : r2_d1);

        n4_l1 = ctsp_pkg::fp_sub(r3_a, r3_h1);
        n4_l2 = ctsp_pkg::fp_sub(r3_b, r3_h2);
        n4_p1 = ctsp_pkg::fp_mul(r3_h1, r3_h2);

        n5_e  = (r4_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_sub(r4_x, r4_p1)
                                                 : ctsp_pkg::fp_add(r4_l1, r4_h2);
        n5_p2 = ctsp_pkg::fp_mul(r4_l1, r4_h2);
        n5_p3 = ctsp_pkg::fp_mul(r4_h1, r4_l2);
        n5_p4 = ctsp_pkg::fp_mul(r4_l1, r4_l2);

        if (r5_op == ctsp_pkg::OP_TWO_PROD) begin
            n6_e = ctsp_pkg::fp_sub(r5_e, r5_p2);
        end else if (r5_ovw) begin
            n6_e = r5_e;
        end else begin
            n6_e = ctsp_pkg::fp_add(r5_err, r5_e);
        end

        n7_e   = (r6_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_sub(r6_e, r6_p3) : r6_e;
        n8_e   = (r7_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_sub(r7_p4, r7_e) : r7_e;
        n9_err = (r8_op == ctsp_pkg::OP_TWO_PROD) ? ctsp_pkg::fp_add(r8_err, r8_e) : r8_e;
    end

    always_ff @(posedge i_clk) begin
        if (flow.en[0]) begin
            r1_op  <= i_op;
            r1_ovw <= i_error_overwrite;
            r1_a   <= i_operand_a;
            r1_b   <= i_operand_b;
            r1_err <= i_error_in;
            r1_x   <= n1_x;
            r1_ca  <= n1_ca;
            r1_cb  <= n1_cb;
        end
        if (flow.en[1]) begin
            r2_op  <= r1_op;
            r2_ovw <= r1_ovw;
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_err <= r1_err;
            r2_x   <= r1_x;
            r2_ca  <= r1_ca;
            r2_cb  <= r1_cb;
            r2_d1  <= n2_d1;
            r2_d2  <= n2_d2;
        end
        if (flow.en[2]) begin
            r3_op  <= r2_op;
            r3_ovw <= r2_ovw;
            r3_a   <= r2_a;
            r3_b   <= r2_b;
            r3_err <= r2_err;
            r3_x   <= r2_x;
            r3_h1  <= n3_h1;
            r3_h2  <= n3_h2;
        end
        if (flow.en[3]) begin
            r4_op  <= r3_op;
            r4_ovw <= r3_ovw;
            r4_err <= r3_err;
            r4_x   <= r3_x;
            r4_h1  <= r3_h1;
            r4_h2  <= r3_h2;
            r4_l1  <= n4_l1;
            r4_l2  <= n4_l2;
            r4_p1  <= n4_p1;
        end
        if (flow.en[4]) begin
            r5_op  <= r4_op;
            r5_ovw <= r4_ovw;
            r5_err <= r4_err;
            r5_x   <= r4_x;
            r5_e   <= n5_e;
            r5_p2  <= n5_p2;
            r5_p3  <= n5_p3;
            r5_p4  <= n5_p4;
        end
        if (flow.en[5]) begin
            r6_op  <= r5_op;
            r6_err <= r5_err;
            r6_x   <= r5_x;
            r6_e   <= n6_e;
            r6_p3  <= r5_p3;
            r6_p4  <= r5_p4;
        end
        if (flow.en[6]) begin
            r7_op  <= r6_op;
            r7_err <= r6_err;
            r7_x   <= r6_x;
            r7_e   <= n7_e;
            r7_p4  <= r6_p4;
        end
        if (flow.en[7]) begin
            r8_op  <= r7_op;
            r8_err <= r7_err;
            r8_x   <= r7_x;
            r8_e   <= n8_e;
        end
        if (flow.en[8]) begin
            r9_x   <= r8_x;
            r9_err <= n9_err;
        end
    end

    assign o_out_valid    = flow.vld[ctsp_pkg::NUM_STAGES-1];
    assign o_result_value = r9_x;
    assign o_error_out    = r9_err;

endmodule

[hw/rtl/ctsp_checker.sv]
// ============================================================================
// ctsp_checker: port-level assertions for the compensated transform block
// Watches handshakes, reset behavior and NaN encoding on the outputs.
// ============================================================================
module ctsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_value,
    input logic [31:0] o_error_out
);

    // A stalled output beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_value) && $stable(o_error_out))
        else $error("output payload changed while stalled");

    // The input side only backs up when the output is stalled.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    // The output is not valid right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A NaN result leaves in canonical quiet form, and so does any NaN error word beside it.
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_value[30:23] == 8'hFF) && (o_result_value[22:0] != 23'h0)
        |-> o_result_value == ctsp_pkg::CANON_NAN
        && !((o_error_out[30:23] == 8'hFF) && (o_error_out[22:0] != 23'h0)
             && (o_error_out != ctsp_pkg::CANON_NAN)))
        else $error("non-canonical NaN on the output");

endmodule

bind compensated_two_sum_two_product ctsp_checker u_ctsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_value (o_result_value),
    .o_error_out    (o_error_out)
);
